// ----- hw/rtl/pas_pkg.sv -----
// ----------------------------------------------------------------------------
// Polygon area statistics package
// Widths, limits, register indexes and the stage records shared by the
// polygon area statistics block.
// ----------------------------------------------------------------------------
package pas_pkg;

  // Field and datapath widths.
  localparam int COORD_W     = 16;
  localparam int PROD_W      = 32;
  localparam int CROSS_W     = 33;
  localparam int ACC_W       = 43;
  localparam int AREA_W      = 42;
  localparam int SUM_W       = 53;
  localparam int VCNT_W      = 11;
  localparam int MATCH_W     = 13;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 11;

  // Limits of the polygon stream.
  localparam int VERTEX_MAX   = 1024;
  localparam int POLYGON_MAX  = 4096;
  localparam int MIN_VERTICES = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_VERTICES = 4'd1;

  // Polygon filter selection.
  typedef enum logic [1:0] {
    FILTER_ALL   = 2'd0,
    FILTER_EVEN  = 2'd1,
    FILTER_ODD   = 2'd2,
    FILTER_EXACT = 2'd3
  } filter_mode_t;

  // One vertex after the tracking stage: operands of the edge cross product
  // and of the closing term, plus the polygon marks.
  typedef struct packed {
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] close_px;
    logic [COORD_W-1:0] close_py;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic               cross_en;
    logic               close;
    logic               set_end;
    logic [VCNT_W-1:0]  count;
  } vtx_t;

  // One vertex after the area stages: closed polygon figures.
  typedef struct packed {
    logic [AREA_W-1:0] twice;
    logic              poly_ok;
    logic              match;
    logic              set_end;
    logic [VCNT_W-1:0] count;
  } poly_t;

endpackage

// ----- hw/rtl/pas_vertex_track.sv -----
// ----------------------------------------------------------------------------
// Polygon vertex tracker
// Keeps the first and previous vertex and the vertex count of the open
// polygon and registers the operands for the shoelace products.
// ----------------------------------------------------------------------------
module pas_vertex_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        take,
  input  logic [pas_pkg::COORD_W-1:0] coord_x,
  input  logic [pas_pkg::COORD_W-1:0] coord_y,
  input  logic                        polygon_end,
  input  logic                        set_end,
  output logic                        vtx_valid,
  output pas_pkg::vtx_t               vtx
);

  localparam logic [pas_pkg::VCNT_W-1:0] VMAX = pas_pkg::VCNT_W'(pas_pkg::VERTEX_MAX);

  logic [pas_pkg::COORD_W-1:0] first_x;
  logic [pas_pkg::COORD_W-1:0] first_y;
  logic [pas_pkg::COORD_W-1:0] prev_x;
  logic [pas_pkg::COORD_W-1:0] prev_y;
  logic [pas_pkg::VCNT_W-1:0]  vcount;

  logic                        is_first;
  logic                        keep;
  logic                        closing;
  logic [pas_pkg::COORD_W-1:0] first_x_next;
  logic [pas_pkg::COORD_W-1:0] first_y_next;
  logic [pas_pkg::COORD_W-1:0] prev_x_next;
  logic [pas_pkg::COORD_W-1:0] prev_y_next;
  logic [pas_pkg::VCNT_W-1:0]  vcount_next;

  // The first vertex opens a polygon; vertices past the limit are dropped.
  always_comb begin
    is_first     = (vcount == '0);
    keep         = !is_first && (vcount < VMAX);
    closing      = polygon_end || set_end;
    first_x_next = is_first ? coord_x : first_x;
    first_y_next = is_first ? coord_y : first_y;
    prev_x_next  = (is_first || keep) ? coord_x : prev_x;
    prev_y_next  = (is_first || keep) ? coord_y : prev_y;
    if (is_first) begin
      vcount_next = pas_pkg::VCNT_W'(1);
    end else if (keep) begin
      vcount_next = vcount + 1'b1;
    end else begin
      vcount_next = vcount;
    end
  end

  // Open polygon state, cleared when the polygon closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      vcount  <= '0;
    end else if (take) begin
      if (closing) begin
        first_x <= '0;
        first_y <= '0;
        prev_x  <= '0;
        prev_y  <= '0;
        vcount  <= '0;
      end else begin
        first_x <= first_x_next;
        first_y <= first_y_next;
        prev_x  <= prev_x_next;
        prev_y  <= prev_y_next;
        vcount  <= vcount_next;
      end
    end
  end

  // Stage register toward the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_valid <= 1'b0;
    end else if (adv) begin
      vtx_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vtx.prev_x   <= prev_x;
      vtx.prev_y   <= prev_y;
      vtx.cur_x    <= coord_x;
      vtx.cur_y    <= coord_y;
      vtx.close_px <= prev_x_next;
      vtx.close_py <= prev_y_next;
      vtx.first_x  <= first_x_next;
      vtx.first_y  <= first_y_next;
      vtx.cross_en <= keep;
      vtx.close    <= closing;
      vtx.set_end  <= set_end;
      vtx.count    <= vcount_next;
    end
  end

endmodule

// ----- hw/rtl/pas_shoelace.sv -----
// ----------------------------------------------------------------------------
// Shoelace area pipeline
// Forms the edge and closing cross products, accumulates them per polygon,
// takes the absolute twice-area and applies the polygon filter.
// ----------------------------------------------------------------------------
module pas_shoelace (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         vtx_valid,
  input  pas_pkg::vtx_t                vtx,
  input  pas_pkg::filter_mode_t        filter_mode,
  input  logic [pas_pkg::VCNT_W-1:0]   exact_vertices,
  output logic                         poly_valid,
  output pas_pkg::poly_t               poly
);

  localparam int CROSS_W = pas_pkg::CROSS_W;
  localparam int ACC_W   = pas_pkg::ACC_W;
  localparam logic [pas_pkg::VCNT_W-1:0] VMIN = pas_pkg::VCNT_W'(pas_pkg::MIN_VERTICES);

  logic signed [pas_pkg::PROD_W-1:0] prod_a;
  logic signed [pas_pkg::PROD_W-1:0] prod_b;
  logic signed [pas_pkg::PROD_W-1:0] prod_c;
  logic signed [pas_pkg::PROD_W-1:0] prod_d;
  logic signed [CROSS_W-1:0]         cross_d;
  logic signed [CROSS_W-1:0]         close_d;

  logic                              s2_valid;
  logic signed [CROSS_W-1:0]         s2_cross;
  logic signed [CROSS_W-1:0]         s2_close_term;
  logic                              s2_close;
  logic                              s2_set_end;
  logic [pas_pkg::VCNT_W-1:0]        s2_count;

  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           acc_sum;
  logic signed [ACC_W-1:0]           total;

  logic                              s3_valid;
  logic signed [ACC_W-1:0]           s3_total;
  logic                              s3_close;
  logic                              s3_set_end;
  logic [pas_pkg::VCNT_W-1:0]        s3_count;

  logic [ACC_W-1:0]                  mag;
  logic                              poly_ok;
  logic                              match;

  // Edge term prev_x*y - x*prev_y and closing term last_x*first_y - first_x*last_y.
  always_comb begin
    prod_a  = $signed(vtx.prev_x) * $signed(vtx.cur_y);
    prod_b  = $signed(vtx.cur_x) * $signed(vtx.prev_y);
    prod_c  = $signed(vtx.close_px) * $signed(vtx.first_y);
    prod_d  = $signed(vtx.first_x) * $signed(vtx.close_py);
    cross_d = vtx.cross_en ? (CROSS_W'(prod_a) - CROSS_W'(prod_b)) : '0;
    close_d = vtx.close ? (CROSS_W'(prod_c) - CROSS_W'(prod_d)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= vtx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cross      <= cross_d;
      s2_close_term <= close_d;
      s2_close      <= vtx.close;
      s2_set_end    <= vtx.set_end;
      s2_count      <= vtx.count;
    end
  end

  // Polygon accumulator; the closing vertex adds both terms and restarts it.
  always_comb begin
    acc_sum = acc + ACC_W'(s2_cross);
    total   = acc_sum + ACC_W'(s2_close_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && s2_valid) begin
      acc <= s2_close ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_total   <= total;
      s3_close   <= s2_close;
      s3_set_end <= s2_set_end;
      s3_count   <= s2_count;
    end
  end

  // Absolute twice-area and filter decision for a closed polygon.
  always_comb begin
    mag     = s3_total[ACC_W-1] ? ACC_W'(-s3_total) : ACC_W'(s3_total);
    poly_ok = s3_close && (s3_count >= VMIN);
    unique case (filter_mode)
      pas_pkg::FILTER_ALL:   match = 1'b1;
      pas_pkg::FILTER_EVEN:  match = !s3_count[0];
      pas_pkg::FILTER_ODD:   match = s3_count[0];
      pas_pkg::FILTER_EXACT: match = (exact_vertices >= VMIN) && (s3_count == exact_vertices);
      default:               match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_valid <= 1'b0;
    end else if (adv) begin
      poly_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      poly.twice   <= mag[pas_pkg::AREA_W-1:0];
      poly.poly_ok <= poly_ok;
      poly.match   <= match;
      poly.set_end <= s3_set_end;
      poly.count   <= s3_count;
    end
  end

endmodule

// ----- hw/rtl/pas_stats.sv -----
// ----------------------------------------------------------------------------
// Polygon set statistics
// Keeps the running sum, matched count and extremes of the polygon set and
// loads the result register on the set-end vertex.
// ----------------------------------------------------------------------------
module pas_stats (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         poly_valid,
  input  pas_pkg::poly_t               poly,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [pas_pkg::SUM_W-1:0]    sum_twice_area,
  output logic [pas_pkg::MATCH_W-1:0]  matched_count,
  output logic [pas_pkg::AREA_W-1:0]   max_twice_area,
  output logic [pas_pkg::AREA_W-1:0]   min_twice_area,
  output logic [pas_pkg::VCNT_W-1:0]   max_vertex_count,
  output logic [pas_pkg::VCNT_W-1:0]   min_vertex_count,
  output logic                         empty_error
);

  localparam int SUM_W = pas_pkg::SUM_W;
  localparam logic [pas_pkg::MATCH_W-1:0] PMAX = pas_pkg::MATCH_W'(pas_pkg::POLYGON_MAX);

  logic [SUM_W-1:0]            run_sum;
  logic [pas_pkg::MATCH_W-1:0] run_matched;
  logic [pas_pkg::AREA_W-1:0]  run_max_area;
  logic [pas_pkg::AREA_W-1:0]  run_min_area;
  logic [pas_pkg::VCNT_W-1:0]  run_max_v;
  logic [pas_pkg::VCNT_W-1:0]  run_min_v;
  logic                        any_seen;

  logic [SUM_W:0]              sum_wide;
  logic [SUM_W-1:0]            run_sum_next;
  logic [pas_pkg::MATCH_W-1:0] run_matched_next;
  logic [pas_pkg::AREA_W-1:0]  run_max_area_next;
  logic [pas_pkg::AREA_W-1:0]  run_min_area_next;
  logic [pas_pkg::VCNT_W-1:0]  run_max_v_next;
  logic [pas_pkg::VCNT_W-1:0]  run_min_v_next;
  logic                        any_seen_next;
  logic                        load;

  // Running figures including the polygon that closes at this vertex.
  always_comb begin
    sum_wide          = {1'b0, run_sum} + (SUM_W + 1)'(poly.twice);
    run_sum_next      = run_sum;
    run_matched_next  = run_matched;
    run_max_area_next = run_max_area;
    run_min_area_next = run_min_area;
    run_max_v_next    = run_max_v;
    run_min_v_next    = run_min_v;
    any_seen_next     = any_seen;
    if (poly.poly_ok) begin
      if (poly.match) begin
        run_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        if (run_matched < PMAX) begin
          run_matched_next = run_matched + 1'b1;
        end
      end
      if (poly.twice > run_max_area) begin
        run_max_area_next = poly.twice;
      end
      if (poly.twice < run_min_area) begin
        run_min_area_next = poly.twice;
      end
      if (poly.count > run_max_v) begin
        run_max_v_next = poly.count;
      end
      if (poly.count < run_min_v) begin
        run_min_v_next = poly.count;
      end
      any_seen_next = 1'b1;
    end
    load = adv && poly_valid;
  end

  // Running state; a set end returns it to the empty-set values.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum      <= '0;
      run_matched  <= '0;
      run_max_area <= '0;
      run_min_area <= '1;
      run_max_v    <= '0;
      run_min_v    <= '1;
      any_seen     <= 1'b0;
    end else if (load) begin
      if (poly.set_end) begin
        run_sum      <= '0;
        run_matched  <= '0;
        run_max_area <= '0;
        run_min_area <= '1;
        run_max_v    <= '0;
        run_min_v    <= '1;
        any_seen     <= 1'b0;
      end else begin
        run_sum      <= run_sum_next;
        run_matched  <= run_matched_next;
        run_max_area <= run_max_area_next;
        run_min_area <= run_min_area_next;
        run_max_v    <= run_max_v_next;
        run_min_v    <= run_min_v_next;
        any_seen     <= any_seen_next;
      end
    end
  end

  // Result register; the pipeline only advances a set end into a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load && poly.set_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && poly.set_end) begin
      if (any_seen_next) begin
        sum_twice_area   <= run_sum_next;
        matched_count    <= run_matched_next;
        max_twice_area   <= run_max_area_next;
        min_twice_area   <= run_min_area_next;
        max_vertex_count <= run_max_v_next;
        min_vertex_count <= run_min_v_next;
        empty_error      <= 1'b0;
      end else begin
        sum_twice_area   <= '0;
        matched_count    <= '0;
        max_twice_area   <= '0;
        min_twice_area   <= '0;
        max_vertex_count <= '0;
        min_vertex_count <= '0;
        empty_error      <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/polygon_area_statistics.sv -----
// ----------------------------------------------------------------------------
// Polygon area statistics
// Shoelace twice-area of each polygon in a vertex stream, with filtered sum,
// matched count and area and vertex-count extremes reported per polygon set.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  vertex    in         vertex_valid/vertex_ready   coord_x, coord_y, polygon_end, set_end
//  result    out        result_valid/result_ready   sum_twice_area .. empty_error
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One vertex request is taken every cycle while vertex_ready is high; the
// set-end vertex passes the tracker, product, accumulator and filter stages
// before its figures are loaded into the result register.
// Reset clears the open polygon, running figures and valid flags; cfg takes its defaults.
// vertex_ready drops only while a set-end vertex waits at the last stage and
// the result register still holds an untaken result.
// cfg_ready is always high.
module polygon_area_statistics (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vertex_valid,
  output logic                             vertex_ready,
  input  logic [pas_pkg::COORD_W-1:0]      coord_x,
  input  logic [pas_pkg::COORD_W-1:0]      coord_y,
  input  logic                             polygon_end,
  input  logic                             set_end,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [pas_pkg::SUM_W-1:0]        sum_twice_area,
  output logic [pas_pkg::MATCH_W-1:0]      matched_count,
  output logic [pas_pkg::AREA_W-1:0]       max_twice_area,
  output logic [pas_pkg::AREA_W-1:0]       min_twice_area,
  output logic [pas_pkg::VCNT_W-1:0]       max_vertex_count,
  output logic [pas_pkg::VCNT_W-1:0]       min_vertex_count,
  output logic                             empty_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pas_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pas_pkg::filter_mode_t        filter_mode;
  logic [pas_pkg::VCNT_W-1:0]   exact_vertices;

  logic                         adv;
  logic                         vtx_valid;
  pas_pkg::vtx_t                vtx;
  logic                         poly_valid;
  pas_pkg::poly_t               poly;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= pas_pkg::FILTER_ALL;
      exact_vertices <= pas_pkg::VCNT_W'(pas_pkg::MIN_VERTICES);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pas_pkg::CFG_FILTER_MODE:    filter_mode <= pas_pkg::filter_mode_t'(cfg_data[1:0]);
        pas_pkg::CFG_EXACT_VERTICES: exact_vertices <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a set end cannot enter the result register.
  assign adv          = !(poly_valid && poly.set_end && result_valid && !result_ready);
  assign vertex_ready = adv;

  pas_vertex_track u_track (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .take        (vertex_valid && adv),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .polygon_end (polygon_end),
    .set_end     (set_end),
    .vtx_valid   (vtx_valid),
    .vtx         (vtx)
  );

  pas_shoelace u_shoelace (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .vtx_valid      (vtx_valid),
    .vtx            (vtx),
    .filter_mode    (filter_mode),
    .exact_vertices (exact_vertices),
    .poly_valid     (poly_valid),
    .poly           (poly)
  );

  pas_stats u_stats (
    .clk              (clk),
    .rst              (rst),
    .adv              (adv),
    .poly_valid       (poly_valid),
    .poly             (poly),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .sum_twice_area   (sum_twice_area),
    .matched_count    (matched_count),
    .max_twice_area   (max_twice_area),
    .min_twice_area   (min_twice_area),
    .max_vertex_count (max_vertex_count),
    .min_vertex_count (min_vertex_count),
    .empty_error      (empty_error)
  );

  // An empty set reports all figures as zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_error |->
      sum_twice_area == '0 && matched_count == '0 && max_twice_area == '0 &&
      min_twice_area == '0 && max_vertex_count == '0 && min_vertex_count == '0)
    else $error("empty set result carries nonzero figures");

  // A non-empty set has ordered extremes and at least a triangle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !empty_error |->
      min_twice_area <= max_twice_area && min_vertex_count <= max_vertex_count &&
      min_vertex_count >= pas_pkg::VCNT_W'(pas_pkg::MIN_VERTICES))
    else $error("result extremes out of order");

  // The matched count saturates at the polygon limit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> matched_count <= pas_pkg::MATCH_W'(pas_pkg::POLYGON_MAX))
    else $error("matched count above limit");

  // The vertex side stalls only behind a waiting result.
  assert property (@(posedge clk) disable iff (rst)
    !vertex_ready |-> result_valid && !result_ready)
    else $error("vertex stall without a waiting result");

endmodule
